// File: hdl/hsp_sat_pkg.sv
// Shared types and constants for the HSP saturation adjust block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package hsp_sat_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } hsp_sat_in_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
    } hsp_sat_out_t;

    typedef enum logic [1:0] {
        REG_FACTOR = 2'd0,
        REG_WEIGHT_RED = 2'd1,
        REG_WEIGHT_GREEN = 2'd2,
        REG_WEIGHT_BLUE = 2'd3
    } hsp_sat_reg_t;

    localparam logic [15:0] FACTOR_RESET = 16'd4096;
    localparam logic [15:0] WEIGHT_RED_RESET = 16'd19595;
    localparam logic [15:0] WEIGHT_GREEN_RESET = 16'd38470;
    localparam logic [15:0] WEIGHT_BLUE_RESET = 16'd7471;

    localparam logic [15:0] NARROW_MAX = 16'h00FF;

    function automatic logic [15:0] chan_max(input logic mode, input int cb);
        logic [16:0] full;
        full = (17'd1 << cb) - 17'd1;
        return mode ? full[15:0] : NARROW_MAX;
    endfunction

endpackage

// File: hdl/hsp_sat_front.sv
// Front end: channel masking, squaring and weighted sum of the squares.
// Three register stages; depends on hsp_sat_pkg.
`timescale 1ns / 1ps

module hsp_sat_front
    import hsp_sat_pkg::*;
#(
    parameter int CB = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_i,
    input  hsp_sat_in_t          pix_i,
    input  logic [15:0]          weight_red,
    input  logic [15:0]          weight_green,
    input  logic [15:0]          weight_blue,
    output logic                 valid_o,
    output hsp_sat_in_t          pix_o,
    output logic [2*CB+17:0]     sum_o
);

    localparam int SQW = 2 * CB;
    localparam int PW = SQW + 16;
    localparam int SW = SQW + 18;

    logic [15:0]    mask;
    hsp_sat_in_t    pix_masked;
    logic [2:0]     valid_reg;
    hsp_sat_in_t    pix1_reg;
    hsp_sat_in_t    pix2_reg;
    hsp_sat_in_t    pix3_reg;
    logic [SQW-1:0] sq_r_reg;
    logic [SQW-1:0] sq_g_reg;
    logic [SQW-1:0] sq_b_reg;
    logic [PW-1:0]  pr_reg;
    logic [PW-1:0]  pg_reg;
    logic [PW-1:0]  pb_reg;
    logic [SW-1:0]  sum_reg;

    always_comb
    begin
        mask = chan_max(pix_i.mode, CB);
        pix_masked.mode = pix_i.mode;
        pix_masked.red_in = pix_i.red_in & mask;
        pix_masked.green_in = pix_i.green_in & mask;
        pix_masked.blue_in = pix_i.blue_in & mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], valid_i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix1_reg <= pix_masked;
            sq_r_reg <= SQW'(pix_masked.red_in[CB-1:0]) * SQW'(pix_masked.red_in[CB-1:0]);
            sq_g_reg <= SQW'(pix_masked.green_in[CB-1:0]) *
                        SQW'(pix_masked.green_in[CB-1:0]);
            sq_b_reg <= SQW'(pix_masked.blue_in[CB-1:0]) * SQW'(pix_masked.blue_in[CB-1:0]);

            pix2_reg <= pix1_reg;
            pr_reg <= PW'(sq_r_reg) * PW'(weight_red);
            pg_reg <= PW'(sq_g_reg) * PW'(weight_green);
            pb_reg <= PW'(sq_b_reg) * PW'(weight_blue);

            pix3_reg <= pix2_reg;
            sum_reg <= SW'(pr_reg) + SW'(pg_reg) + SW'(pb_reg);
        end
    end

    assign valid_o = valid_reg[2];
    assign pix_o = pix3_reg;
    assign sum_o = sum_reg;

endmodule

// File: hdl/hsp_sat_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
// Passes radicand, remainder, partial root and pixel on; uses hsp_sat_pkg.
`timescale 1ns / 1ps

module hsp_sat_sqrt_cell
    import hsp_sat_pkg::*;
#(
    parameter int RW = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_i,
    input  logic [2*RW-1:0]   rad_i,
    input  logic [RW+1:0]     rem_i,
    input  logic [RW-1:0]     root_i,
    input  hsp_sat_in_t       pix_i,
    output logic              valid_o,
    output logic [2*RW-1:0]   rad_o,
    output logic [RW+1:0]     rem_o,
    output logic [RW-1:0]     root_o,
    output hsp_sat_in_t       pix_o
);

    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;
    logic            valid_reg;
    logic [2*RW-1:0] rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    hsp_sat_in_t     pix_reg;

    always_comb
    begin
        rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
        trial = {root_i, 2'b01};
        ge = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= {rad_i[2*RW-3:0], 2'b00};
            rem_reg <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_i[RW-2:0], ge};
            pix_reg <= pix_i;
        end
    end

    assign valid_o = valid_reg;
    assign rad_o = rad_reg;
    assign rem_o = rem_reg;
    assign root_o = root_reg;
    assign pix_o = pix_reg;

endmodule

// File: hdl/hsp_sat_adjust.sv
// Saturation push and clamp for all three channels against brightness P.
// One multiply stage, then add, clamp and truncate; uses hsp_sat_pkg.
`timescale 1ns / 1ps

module hsp_sat_adjust
    import hsp_sat_pkg::*;
#(
    parameter int CB = 16,
    parameter int RW = 25
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_i,
    input  logic [RW-1:0] p8_i,
    input  hsp_sat_in_t   pix_i,
    input  logic [15:0]   factor,
    output logic          valid_o,
    output hsp_sat_out_t  res_o
);

    localparam int DW = RW + 2;
    localparam int PW = DW + 17;
    localparam int VW = PW + 1;

    logic signed [DW-1:0] diff_r;
    logic signed [DW-1:0] diff_g;
    logic signed [DW-1:0] diff_b;
    logic signed [16:0]   fac_s;
    logic                 valid_reg;
    logic                 mode_reg;
    logic [RW-1:0]        p8_reg;
    logic signed [PW-1:0] prod_r_reg;
    logic signed [PW-1:0] prod_g_reg;
    logic signed [PW-1:0] prod_b_reg;
    logic [CB-1:0]        maxv;
    logic signed [VW-1:0] base;
    logic signed [VW-1:0] lim;

    function automatic logic signed [DW-1:0] chan_diff(input logic [CB-1:0] c,
                                                       input logic [RW-1:0] p);
        return $signed({{(DW-CB-8){1'b0}}, c, 8'b0}) - $signed({2'b00, p});
    endfunction

    function automatic logic [15:0] clamp(input logic signed [PW-1:0] prod,
                                          input logic signed [VW-1:0] b,
                                          input logic signed [VW-1:0] l,
                                          input logic [CB-1:0] m);
        logic signed [VW-1:0] v;
        logic [VW-21:0]       q;
        v = $signed({{(VW-PW){prod[PW-1]}}, prod}) + b;
        q = v[VW-1:20];
        if (v[VW-1])
        begin
            return 16'd0;
        end
        else if (v > l)
        begin
            return 16'(m);
        end
        return 16'(q);
    endfunction

    always_comb
    begin
        fac_s = $signed({1'b0, factor});
        diff_r = chan_diff(pix_i.red_in[CB-1:0], p8_i);
        diff_g = chan_diff(pix_i.green_in[CB-1:0], p8_i);
        diff_b = chan_diff(pix_i.blue_in[CB-1:0], p8_i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg <= pix_i.mode;
            p8_reg <= p8_i;
            prod_r_reg <= PW'(diff_r) * PW'(fac_s);
            prod_g_reg <= PW'(diff_g) * PW'(fac_s);
            prod_b_reg <= PW'(diff_b) * PW'(fac_s);
        end
    end

    always_comb
    begin
        maxv = CB'(chan_max(mode_reg, CB));
        base = $signed({{(VW-RW-12){1'b0}}, p8_reg, 12'b0});
        lim = $signed({{(VW-CB-20){1'b0}}, maxv, 20'b0});
        res_o.red_out = clamp(prod_r_reg, base, lim, maxv);
        res_o.green_out = clamp(prod_g_reg, base, lim, maxv);
        res_o.blue_out = clamp(prod_b_reg, base, lim, maxv);
    end

    assign valid_o = valid_reg;

endmodule

// File: hdl/hsp_saturation_adjust_top.sv
// Top level of the HSP saturation adjust block: APB registers, front end,
// square root cell chain, adjust stage and output skid; uses hsp_sat_pkg.
//
//  channel  | direction | handshake                 | payload
//  src      | in        | src_valid / src_ready     | src_data  (hsp_sat_in_t)
//  dst      | out       | dst_valid / dst_ready     | dst_data  (hsp_sat_out_t)
//  apb      | in/out    | psel, penable, pready     | paddr, pwdata, prdata
//
// One item per cycle while src_ready is high; each item passes through three
// front stages, one square root cell per root bit, one multiply stage and
// the output register.
// Reset restores register defaults and empties every stage.
// An output register plus one skid entry: src_ready drops while a result is
// parked in the skid entry and rises once it moves out.
`timescale 1ns / 1ps

module hsp_saturation_adjust_top
    import hsp_sat_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         src_valid,
    output logic         src_ready,
    input  hsp_sat_in_t  src_data,
    output logic         dst_valid,
    input  logic         dst_ready,
    output hsp_sat_out_t dst_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int RW = CHANNEL_BITS + 9;
    localparam int SW = 2 * RW;

    logic [15:0]  factor_reg;
    logic [15:0]  weight_red_reg;
    logic [15:0]  weight_green_reg;
    logic [15:0]  weight_blue_reg;
    hsp_sat_reg_t reg_sel;
    logic         en;

    logic          front_valid;
    hsp_sat_in_t   front_pix;
    logic [SW-1:0] front_sum;

    logic          chain_valid [0:RW];
    logic [SW-1:0] chain_rad [0:RW];
    logic [RW+1:0] chain_rem [0:RW];
    logic [RW-1:0] chain_root [0:RW];
    hsp_sat_in_t   chain_pix [0:RW];

    logic         res_valid;
    hsp_sat_out_t res;
    logic         out_valid_reg;
    hsp_sat_out_t out_reg;
    logic         skid_valid_reg;
    hsp_sat_out_t skid_reg;

    assign reg_sel = hsp_sat_reg_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RESET;
            weight_red_reg <= WEIGHT_RED_RESET;
            weight_green_reg <= WEIGHT_GREEN_RESET;
            weight_blue_reg <= WEIGHT_BLUE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_sel)
                REG_FACTOR:       factor_reg <= pwdata[15:0];
                REG_WEIGHT_RED:   weight_red_reg <= pwdata[15:0];
                REG_WEIGHT_GREEN: weight_green_reg <= pwdata[15:0];
                REG_WEIGHT_BLUE:  weight_blue_reg <= pwdata[15:0];
                default:          factor_reg <= factor_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FACTOR:       prdata = {16'd0, factor_reg};
            REG_WEIGHT_RED:   prdata = {16'd0, weight_red_reg};
            REG_WEIGHT_GREEN: prdata = {16'd0, weight_green_reg};
            REG_WEIGHT_BLUE:  prdata = {16'd0, weight_blue_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign en = !skid_valid_reg;
    assign src_ready = en;

    hsp_sat_front #(
        .CB (CHANNEL_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .valid_i      (src_valid),
        .pix_i        (src_data),
        .weight_red   (weight_red_reg),
        .weight_green (weight_green_reg),
        .weight_blue  (weight_blue_reg),
        .valid_o      (front_valid),
        .pix_o        (front_pix),
        .sum_o        (front_sum)
    );

    assign chain_valid[0] = front_valid;
    assign chain_rad[0] = front_sum;
    assign chain_rem[0] = '0;
    assign chain_root[0] = '0;
    assign chain_pix[0] = front_pix;

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        hsp_sat_sqrt_cell #(
            .RW (RW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid_i (chain_valid[i]),
            .rad_i   (chain_rad[i]),
            .rem_i   (chain_rem[i]),
            .root_i  (chain_root[i]),
            .pix_i   (chain_pix[i]),
            .valid_o (chain_valid[i+1]),
            .rad_o   (chain_rad[i+1]),
            .rem_o   (chain_rem[i+1]),
            .root_o  (chain_root[i+1]),
            .pix_o   (chain_pix[i+1])
        );
    end

    hsp_sat_adjust #(
        .CB (CHANNEL_BITS),
        .RW (RW)
    ) u_adjust (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (chain_valid[RW]),
        .p8_i    (chain_root[RW]),
        .pix_i   (chain_pix[RW]),
        .factor  (factor_reg),
        .valid_o (res_valid),
        .res_o   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && dst_ready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (out_valid_reg)
        begin
            if (en && res_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && dst_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (out_valid_reg)
        begin
            if (en)
            begin
                skid_reg <= res;
            end
        end
        else
        begin
            out_reg <= res;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_data = out_reg;

endmodule
